// ===== rtl/fdtp_pkg.sv =====
// Shared types and constants of the dead-time plant emulator.
// No dependencies; imported by fdtp_step and first_order_dead_time_plant.
`default_nettype none

package fdtp_pkg;

  // Configuration register map
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_GAIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_GAIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY_LEN  = 2'd2;

  // Fixed register width and reset values
  localparam int LEN_REG_W      = 12;
  localparam int DRIVE_GAIN_RST = 3355;
  localparam int DECAY_GAIN_RST = 4194;
  localparam logic [LEN_REG_W-1:0] DELAY_LEN_RST = 12'd1100;

  // Stage valids of the update pipeline, one word in flight per stage
  typedef struct packed {
    logic c1;  // delayed sample valid: drive product
    logic c2;  // low partial of decay product, partial sum
    logic c3;  // high partial, accumulator write-back
  } fdtp_stage_t;

endpackage

`default_nettype wire

// ===== rtl/fdtp_step.sv =====
// Forward-Euler accumulator update: acc += a*u_del - floor(b*acc), saturated.
// Depends on fdtp_pkg (stage valid struct).
`default_nettype none

module fdtp_step import fdtp_pkg::*; #(
  parameter int SAMPLE_BITS    = 16,
  parameter int COEF_FRAC_BITS = 24
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  fdtp_stage_t                     ctrl_i,
  input  wire  [COEF_FRAC_BITS-1:0]       drive_gain_i,
  input  wire  [COEF_FRAC_BITS-1:0]       decay_gain_i,
  input  wire  signed [SAMPLE_BITS-1:0]   u_del_i,
  output logic signed [SAMPLE_BITS-1:0]   y_o
);

  localparam int C     = COEF_FRAC_BITS;
  localparam int ACC_W = SAMPLE_BITS + C;
  localparam int MB_W  = ((SAMPLE_BITS > C) ? SAMPLE_BITS : C) + 1;
  localparam int PR_W  = C + 1 + MB_W;
  localparam int T_W   = PR_W + 1;
  localparam int D_W   = T_W + 1;

  localparam logic signed [D_W-1:0] ACC_MAX = D_W'({1'b0, {(ACC_W-1){1'b1}}});
  localparam logic signed [D_W-1:0] ACC_MIN = ~ACC_MAX;

  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic signed [ACC_W-1:0] p_q;
  logic signed [ACC_W:0]   s_q;
  logic        [2*C-1:0]   pp_lo_q;

  logic signed [C:0]       ga, gb;
  logic signed [ACC_W:0]   p_full;
  logic signed [MB_W-1:0]  mb;
  logic signed [PR_W-1:0]  prod;
  logic signed [T_W-1:0]   q;
  logic signed [D_W-1:0]   diff;

  assign ga     = {1'b0, drive_gain_i};
  assign gb     = {1'b0, decay_gain_i};
  assign p_full = ga * u_del_i;

  // shared decay multiplier: low half of acc in c2, signed high half in c3
  always_comb begin
    if (ctrl_i.c3) begin
      mb = MB_W'(signed'(acc_q[ACC_W-1:C]));
    end else begin
      mb = MB_W'(acc_q[C-1:0]);
    end
  end

  assign prod = gb * mb;

  // floor(b*acc / 2^C) = high partial + carry-in of low partial
  assign q    = T_W'(prod) + T_W'(pp_lo_q[2*C-1:C]);
  assign diff = D_W'(s_q) - D_W'(q);

  always_comb begin
    priority if (diff > ACC_MAX) begin
      acc_d = {1'b0, {(ACC_W-1){1'b1}}};
    end else if (diff < ACC_MIN) begin
      acc_d = {1'b1, {(ACC_W-1){1'b0}}};
    end else begin
      acc_d = diff[ACC_W-1:0];
    end
  end

  assign y_o = acc_d[ACC_W-1:C];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.c1) begin
      p_q <= p_full[ACC_W-1:0];
    end
    if (ctrl_i.c2) begin
      pp_lo_q <= prod[2*C-1:0];
      s_q     <= (ACC_W+1)'(acc_q) + (ACC_W+1)'(p_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (ctrl_i.c3) begin
      acc_q <= acc_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/first_order_dead_time_plant.sv =====
// First-order plant with transport delay: delay ring memory, config, output FIFO.
// Depends on fdtp_pkg and fdtp_step.
`default_nettype none

// Channel   Dir  Handshake          Payload (low bit up)
// s_*       in   s_tvalid/s_tready  s_tdata: drive_sample
// m_*       out  m_tvalid/m_tready  m_tdata: plant_output
// cfg_*     in   cfg_we_i           cfg_idx_i register, cfg_data_i value
//
// Words are taken no faster than the accumulator loop allows (shared decay
// multiplier, two passes); a new word can be taken before the last is through.
// An accepted word passes stages c1, c2 and c3; its result enters the output FIFO in c3.
// After reset a clearing pass zeroes every entry of the delay ring with
// s_tready low; config writes are taken during it.
// Output stalls back up through a 4-word FIFO; besides the cycle after each
// accept, s_tready drops when 4 words are in flight or waiting.

module first_order_dead_time_plant import fdtp_pkg::*; #(
  parameter int MAX_DELAY      = 2048,
  parameter int SAMPLE_BITS    = 16,
  parameter int COEF_FRAC_BITS = 24
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  s_tvalid,
  output logic                 s_tready,
  input  wire  [((SAMPLE_BITS+7)/8)*8-1:0] s_tdata,  // [SAMPLE_BITS-1:0] drive_sample
  output logic                 m_tvalid,
  input  wire                  m_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0] m_tdata,  // [SAMPLE_BITS-1:0] plant_output
  input  wire                  cfg_we_i,
  input  wire  [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire  [((COEF_FRAC_BITS > LEN_REG_W) ? COEF_FRAC_BITS : LEN_REG_W)-1:0] cfg_data_i
);

  localparam int TD_W   = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int IDX_W  = $clog2(MAX_DELAY);
  localparam int LEN_W  = $clog2(MAX_DELAY + 1);
  localparam int LCMP_W = (LEN_W > LEN_REG_W) ? LEN_W : LEN_REG_W;
  localparam int FIFO_DEPTH = 4;
  localparam int FPTR_W = 2;
  localparam int CNT_W  = 3;
  localparam logic [CNT_W-1:0] OCC_MAX = CNT_W'(FIFO_DEPTH);

  // config registers
  logic [COEF_FRAC_BITS-1:0] drive_gain_q, decay_gain_q;
  logic [LEN_REG_W-1:0]      delay_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drive_gain_q <= COEF_FRAC_BITS'(DRIVE_GAIN_RST);
      decay_gain_q <= COEF_FRAC_BITS'(DECAY_GAIN_RST);
      delay_len_q  <= DELAY_LEN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DRIVE_GAIN: drive_gain_q <= cfg_data_i[COEF_FRAC_BITS-1:0];
        REG_DECAY_GAIN: decay_gain_q <= cfg_data_i[COEF_FRAC_BITS-1:0];
        REG_DELAY_LEN:  delay_len_q  <= cfg_data_i[LEN_REG_W-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // ring addressing: clamp length to 1..MAX_DELAY, clamp index under length
  logic [LCMP_W-1:0] len_ext, len_eff, max_len;
  logic [IDX_W-1:0]  len_m1, wi_q, wi_eff, ri;

  always_comb begin
    len_ext = LCMP_W'(delay_len_q);
    max_len = LCMP_W'(MAX_DELAY);
    if (len_ext == '0) begin
      len_eff = LCMP_W'(1);
    end else if (len_ext > max_len) begin
      len_eff = max_len;
    end else begin
      len_eff = len_ext;
    end
    len_m1 = IDX_W'(len_eff - LCMP_W'(1));
    wi_eff = (LCMP_W'(wi_q) >= len_eff) ? len_m1 : wi_q;
    ri     = (wi_eff == '0) ? len_m1 : (wi_eff - IDX_W'(1));
  end

  // handshake and occupancy
  fdtp_stage_t stg_q;
  logic        clearing_q;
  logic [IDX_W-1:0] clr_q;
  logic [CNT_W-1:0] occ_q, fcnt_q;
  logic        s_acc, m_acc;

  assign s_tready = !clearing_q && !stg_q.c1 && (occ_q < OCC_MAX);
  assign s_acc    = s_tvalid && s_tready;
  assign m_tvalid = (fcnt_q != '0);
  assign m_acc    = m_tvalid && m_tready;

  // delay ring memory, one write and one registered read per cycle
  logic [SAMPLE_BITS-1:0] ring_mem [MAX_DELAY];
  logic [SAMPLE_BITS-1:0] rdata_q, u_q;
  logic                   fwd_q;
  logic                   mem_we;
  logic [IDX_W-1:0]       mem_waddr;
  logic [SAMPLE_BITS-1:0] mem_wdata;

  always_comb begin
    if (clearing_q) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
      mem_wdata = '0;
    end else begin
      mem_we    = s_acc;
      mem_waddr = wi_eff;
      mem_wdata = s_tdata[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_mem[mem_waddr] <= mem_wdata;
    end
    if (s_acc) begin
      rdata_q <= ring_mem[ri];
      u_q     <= s_tdata[SAMPLE_BITS-1:0];
      fwd_q   <= (ri == wi_eff);  // length one: read back the new sample
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_q      <= '0;
      wi_q       <= '0;
      stg_q      <= '0;
    end else begin
      if (clearing_q) begin
        if (clr_q == IDX_W'(MAX_DELAY - 1)) begin
          clearing_q <= 1'b0;
        end
        clr_q <= clr_q + IDX_W'(1);
      end
      if (s_acc) begin
        wi_q <= ri;
      end
      stg_q.c1 <= s_acc;
      stg_q.c2 <= stg_q.c1;
      stg_q.c3 <= stg_q.c2;
    end
  end

  // accumulator update
  logic signed [SAMPLE_BITS-1:0] u_del, y;

  assign u_del = fwd_q ? u_q : rdata_q;

  fdtp_step #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_step (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (stg_q),
    .drive_gain_i (drive_gain_q),
    .decay_gain_i (decay_gain_q),
    .u_del_i      (u_del),
    .y_o          (y)
  );

  // output FIFO; space is reserved at accept time, so pushes never stall
  logic [SAMPLE_BITS-1:0] fifo_q [FIFO_DEPTH];
  logic [FPTR_W-1:0]      wr_ptr_q, rd_ptr_q;

  always_ff @(posedge clk_i) begin
    if (stg_q.c3) begin
      fifo_q[wr_ptr_q] <= y;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fcnt_q   <= '0;
      occ_q    <= '0;
    end else begin
      if (stg_q.c3) begin
        wr_ptr_q <= wr_ptr_q + FPTR_W'(1);
      end
      if (m_acc) begin
        rd_ptr_q <= rd_ptr_q + FPTR_W'(1);
      end
      fcnt_q <= fcnt_q + CNT_W'(stg_q.c3) - CNT_W'(m_acc);
      occ_q  <= occ_q + CNT_W'(s_acc) - CNT_W'(m_acc);
    end
  end

  assign m_tdata = TD_W'(fifo_q[rd_ptr_q]);

endmodule

`default_nettype wire
